/* hdl/nec_ir_frame_decoder_assert.svh */
// Assertion macros for the NEC IR frame decoder.
// Expects clk and rst_n in the scope of use.
`ifndef NEC_IR_FRAME_DECODER_ASSERT_SVH
`define NEC_IR_FRAME_DECODER_ASSERT_SVH

`define NIR_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nir: implication check failed");

`define NIR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nir: next-cycle check failed");

`endif

/* hdl/nir_pkg.sv */
// Shared types, constants and key table for the NEC IR frame decoder.
// No dependencies.
package nir_pkg;

  localparam int FRAME_BITS    = 32;
  localparam int REPEAT_DIVIDE = 2;
  localparam int SLOW_REPEAT   = 5;
  localparam int KEY_COUNT     = 30;
  localparam int TABLE_SIZE    = 30;
  localparam int KEY_SCAN      = (KEY_COUNT < TABLE_SIZE) ? KEY_COUNT : TABLE_SIZE;

  localparam int TIME_W    = 32;
  localparam int WIN_W     = 16;
  localparam int CNT_W     = 6;
  localparam int KEY_W     = 5;
  localparam int CMD_W     = 8;
  localparam int EV_W      = 2;
  localparam int DIV_W     = 2;
  localparam int SLOW_W    = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [15:0] CUSTOMER_CODE = 16'h01FE;

  typedef logic [EV_W-1:0] ev_t;
  localparam ev_t EV_NONE  = 2'd0;
  localparam ev_t EV_PRESS = 2'd1;
  localparam ev_t EV_LONG  = 2'd2;

  typedef logic [CFG_IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_ONE_MIN    = 3'd0;
  localparam reg_idx_t REG_ONE_MAX    = 3'd1;
  localparam reg_idx_t REG_ZERO_MIN   = 3'd2;
  localparam reg_idx_t REG_ZERO_MAX   = 3'd3;
  localparam reg_idx_t REG_LEADER_MIN = 3'd4;
  localparam reg_idx_t REG_LEADER_MAX = 3'd5;
  localparam reg_idx_t REG_REPEAT_MIN = 3'd6;
  localparam reg_idx_t REG_REPEAT_MAX = 3'd7;

  typedef struct packed {
    logic [WIN_W-1:0] one_min;
    logic [WIN_W-1:0] one_max;
    logic [WIN_W-1:0] zero_min;
    logic [WIN_W-1:0] zero_max;
    logic [WIN_W-1:0] ldr_min;
    logic [WIN_W-1:0] ldr_max;
    logic [WIN_W-1:0] rpt_min;
    logic [WIN_W-1:0] rpt_max;
  } win_cfg_t;

  typedef struct packed {
    logic one;
    logic zero;
    logic leader;
    logic rpt;
  } cls_t;

  typedef struct packed {
    logic             hit;
    logic [KEY_W-1:0] key;
    logic [CMD_W-1:0] cmd;
  } frame_res_t;

  localparam logic [CMD_W-1:0] KEY_CODE [TABLE_SIZE] = '{
    8'h50, 8'h30, 8'hc0, 8'h40, 8'h78, 8'h38, 8'h00, 8'h80,
    8'h60, 8'ha0, 8'h48, 8'h28, 8'ha8, 8'h68, 8'he8, 8'h18,
    8'h98, 8'h58, 8'h08, 8'hd8, 8'hf8, 8'he0, 8'hf0, 8'h02,
    8'hb8, 8'hd0, 8'h70, 8'h10, 8'h90, 8'h32
  };

  // volume, echo and mic keys repeat fast
  localparam logic [TABLE_SIZE-1:0] KEY_FAST = 30'h06C0000C;

  function automatic logic key_is_fast(input logic [KEY_W-1:0] k);
    logic r;
    r = 1'b0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (k == KEY_W'(i)) begin
        r = KEY_FAST[i];
      end
    end
    return r;
  endfunction

endpackage

/* hdl/nir_chan_if.sv */
// Valid/ready channel interfaces for edge items and decode results.
// Depends on nir_pkg.
interface nir_in_if import nir_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] edge_time_us;
  logic              line_high;

  modport source (output valid, edge_time_us, line_high, input ready);
  modport sink   (input valid, edge_time_us, line_high, output ready);
endinterface

interface nir_out_if import nir_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [EV_W-1:0]  event_kind;
  logic [KEY_W-1:0] key_index;
  logic [CMD_W-1:0] command_byte;

  modport source (output valid, event_kind, key_index, command_byte, input ready);
  modport sink   (input valid, event_kind, key_index, command_byte, output ready);
endinterface

/* hdl/nec_ir_frame_decoder.sv */
// NEC IR frame decoder top level: edge register, decode state, result register.
// Depends on nir_pkg, nir_chan_if, nir_cfg_regs, nir_classify, nir_frame_check
// and nec_ir_frame_decoder_assert.svh.
//
// in_chan carries one receiver edge per transfer: a microsecond timestamp and
// the line level. Every transfer yields exactly one result on out_chan, whose
// event_kind is none, key press or long press. Edges with the line high give
// an empty result and touch no state.
// An edge is registered at its transfer, decoded from that register and the
// decode state, and its result is registered when the edge register advances;
// one edge per cycle is taken as long as results are drained. The edge
// register advances whenever the result register is empty or being taken, so
// edges flow back to back while results are taken.
// When out_chan.ready is low, the result holds and at most one more edge is
// taken into the edge register; in_chan.ready then drops.
// Synchronous reset empties both registers, clears the frame state and loads
// the window registers with their defaults. Write the cfg_ registers only
// while no result is outstanding.
`include "nec_ir_frame_decoder_assert.svh"

module nec_ir_frame_decoder import nir_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  nir_in_if.sink               in_chan,
  nir_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WIN_W-1:0]     cfg_wdata
);

  win_cfg_t   win_cfg;
  cls_t       cls;
  frame_res_t frame_res;

  logic                  s1_valid_r, s1_valid_nxt;
  logic [TIME_W-1:0]     s1_time_r;
  logic                  s1_high_r;
  logic                  s1_adv;
  logic                  in_fire;

  logic [TIME_W-1:0]     prev_r, prev_nxt;
  logic [CNT_W-1:0]      bit_cnt_r, bit_cnt_nxt;
  logic [FRAME_BITS-1:0] shift_r, shift_nxt, shift_cand;
  logic                  rearm_r, rearm_nxt;
  logic [DIV_W-1:0]      div_r, div_nxt, div_dec;
  logic [SLOW_W-1:0]     slow_r, slow_nxt, slow_dec;
  logic [KEY_W-1:0]      last_key_r, last_key_nxt;
  logic                  last_valid_r, last_valid_nxt;
  logic                  fire;

  logic                  out_valid_r, out_valid_nxt;
  ev_t                   ev_r, ev_nxt;
  logic [KEY_W-1:0]      key_r, key_nxt;
  logic [CMD_W-1:0]      cmd_r, cmd_nxt;

  nir_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .win_cfg   (win_cfg)
  );

  nir_classify u_cls (
    .win_cfg   (win_cfg),
    .prev_time (prev_r),
    .edge_time (s1_time_r),
    .cls       (cls)
  );

  assign shift_cand = {shift_r[FRAME_BITS-2:0], cls.one};

  nir_frame_check u_chk (
    .frame (shift_cand),
    .res   (frame_res)
  );

  assign s1_adv        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_comb begin
    s1_valid_nxt = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_adv ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);
  end

  always_comb begin
    prev_nxt       = prev_r;
    bit_cnt_nxt    = bit_cnt_r;
    shift_nxt      = shift_r;
    rearm_nxt      = rearm_r;
    div_nxt        = div_r;
    slow_nxt       = slow_r;
    last_key_nxt   = last_key_r;
    last_valid_nxt = last_valid_r;
    div_dec        = div_r - 1'b1;
    slow_dec       = slow_r - 1'b1;
    fire           = 1'b0;
    ev_nxt         = EV_NONE;
    key_nxt        = '0;
    cmd_nxt        = '0;
    if (s1_adv && !s1_high_r) begin
      prev_nxt = s1_time_r;
      if (rearm_r) begin
        rearm_nxt = 1'b0;
      end else begin
        if (cls.one || cls.zero) begin
          shift_nxt   = shift_cand;
          bit_cnt_nxt = bit_cnt_r + 1'b1;
        end else if (cls.leader) begin
          bit_cnt_nxt = '0;
          shift_nxt   = '0;
          div_nxt     = DIV_W'(REPEAT_DIVIDE);
        end else if (cls.rpt) begin
          if (div_dec == '0) begin
            if (key_is_fast(last_key_r)) begin
              fire = 1'b1;
            end else if (slow_dec == '0) begin
              fire     = 1'b1;
              slow_nxt = SLOW_W'(SLOW_REPEAT);
            end else begin
              slow_nxt = slow_dec;
            end
            if (fire && last_valid_r) begin
              ev_nxt  = EV_LONG;
              key_nxt = last_key_r;
            end
            div_nxt = DIV_W'(REPEAT_DIVIDE);
          end else begin
            div_nxt = div_dec;
          end
        end
        if (bit_cnt_nxt >= CNT_W'(FRAME_BITS)) begin
          if (frame_res.hit) begin
            last_key_nxt   = frame_res.key;
            last_valid_nxt = 1'b1;
            ev_nxt         = EV_PRESS;
            key_nxt        = frame_res.key;
            cmd_nxt        = frame_res.cmd;
          end
          bit_cnt_nxt = '0;
          shift_nxt   = '0;
          rearm_nxt   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      prev_r       <= '0;
      bit_cnt_r    <= '0;
      shift_r      <= '0;
      rearm_r      <= 1'b0;
      div_r        <= DIV_W'(REPEAT_DIVIDE);
      slow_r       <= SLOW_W'(SLOW_REPEAT);
      last_key_r   <= '0;
      last_valid_r <= 1'b0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      prev_r       <= prev_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      shift_r      <= shift_nxt;
      rearm_r      <= rearm_nxt;
      div_r        <= div_nxt;
      slow_r       <= slow_nxt;
      last_key_r   <= last_key_nxt;
      last_valid_r <= last_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_time_r <= in_chan.edge_time_us;
      s1_high_r <= in_chan.line_high;
    end
    if (s1_adv) begin
      ev_r  <= ev_nxt;
      key_r <= key_nxt;
      cmd_r <= cmd_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.event_kind   = ev_r;
  assign out_chan.key_index    = key_r;
  assign out_chan.command_byte = cmd_r;

  `NIR_ASSERT_IMPLY(a_none_empty, out_valid_r && (ev_r == EV_NONE), (key_r == '0) && (cmd_r == '0))
  `NIR_ASSERT_IMPLY(a_long_no_cmd, out_valid_r && (ev_r == EV_LONG), (cmd_r == '0) && last_valid_r)
  `NIR_ASSERT_IMPLY(a_press_key, out_valid_r && (ev_r == EV_PRESS), last_valid_r && rearm_r)
  `NIR_ASSERT_IMPLY(a_rearm_clear, rearm_r, (bit_cnt_r == '0) && (shift_r == '0))
  `NIR_ASSERT_NEXT(a_rearm_once, s1_adv && !s1_high_r && rearm_r, !rearm_r)

endmodule

/* hdl/nir_cfg_regs.sv */
// Timing window registers with their reset values.
// Depends on nir_pkg.
module nir_cfg_regs import nir_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WIN_W-1:0]     cfg_wdata,
  output win_cfg_t             win_cfg
);

  win_cfg_t win_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.one_min  <= 16'd1850;
      win_r.one_max  <= 16'd2750;
      win_r.zero_min <= 16'd720;
      win_r.zero_max <= 16'd1520;
      win_r.ldr_min  <= 16'd13000;
      win_r.ldr_max  <= 16'd13900;
      win_r.rpt_min  <= 16'd10750;
      win_r.rpt_max  <= 16'd11750;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ONE_MIN:    win_r.one_min  <= cfg_wdata;
        REG_ONE_MAX:    win_r.one_max  <= cfg_wdata;
        REG_ZERO_MIN:   win_r.zero_min <= cfg_wdata;
        REG_ZERO_MAX:   win_r.zero_max <= cfg_wdata;
        REG_LEADER_MIN: win_r.ldr_min  <= cfg_wdata;
        REG_LEADER_MAX: win_r.ldr_max  <= cfg_wdata;
        REG_REPEAT_MIN: win_r.rpt_min  <= cfg_wdata;
        REG_REPEAT_MAX: win_r.rpt_max  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign win_cfg = win_r;

endmodule

/* hdl/nir_classify.sv */
// Interval measurement and window classification of one edge.
// Depends on nir_pkg.
module nir_classify import nir_pkg::*; (
  input  win_cfg_t          win_cfg,
  input  logic [TIME_W-1:0] prev_time,
  input  logic [TIME_W-1:0] edge_time,
  output cls_t              cls
);

  logic [TIME_W-1:0] base;
  logic [TIME_W-1:0] width;
  logic              w_one, w_zero, w_leader, w_rpt;

  function automatic logic in_win(input logic [TIME_W-1:0] w,
                                  input logic [WIN_W-1:0] lo,
                                  input logic [WIN_W-1:0] hi);
    return (w >= TIME_W'(lo)) && (w <= TIME_W'(hi));
  endfunction

  assign base     = (prev_time > edge_time) ? '0 : prev_time;
  assign width    = edge_time - base;
  assign w_one    = in_win(width, win_cfg.one_min, win_cfg.one_max);
  assign w_zero   = in_win(width, win_cfg.zero_min, win_cfg.zero_max);
  assign w_leader = in_win(width, win_cfg.ldr_min, win_cfg.ldr_max);
  assign w_rpt    = in_win(width, win_cfg.rpt_min, win_cfg.rpt_max);

  assign cls.one    = w_one;
  assign cls.zero   = !w_one && w_zero;
  assign cls.leader = !w_one && !w_zero && w_leader;
  assign cls.rpt    = !w_one && !w_zero && !w_leader && w_rpt;

endmodule

/* hdl/nir_frame_check.sv */
// Frame check: customer code, command inverse and key table match.
// Depends on nir_pkg.
module nir_frame_check import nir_pkg::*; (
  input  logic [FRAME_BITS-1:0] frame,
  output frame_res_t            res
);

  logic [CMD_W-1:0] cmd;
  logic             frame_ok;
  logic             hit;
  logic [KEY_W-1:0] key;

  assign cmd      = frame[15:8];
  assign frame_ok = (frame[31:16] == CUSTOMER_CODE) && (frame[7:0] == ~cmd);

  always_comb begin
    hit = 1'b0;
    key = '0;
    for (int i = KEY_SCAN - 1; i >= 0; i--) begin
      if (KEY_CODE[i] == cmd) begin
        hit = 1'b1;
        key = KEY_W'(i);
      end
    end
  end

  assign res.hit = frame_ok && hit;
  assign res.key = key;
  assign res.cmd = cmd;

endmodule
